@@ rtl/esort_pkg.sv @@
// ----------------------------------------------------------------------------
// esort_pkg
// Shared types and constants of the exchange sort engine.
// ----------------------------------------------------------------------------
package esort_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_COUNT_DEF = 16;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT_START,
        ST_OUTER_WAIT,
        ST_INNER,
        ST_OUTER_END,
        ST_EMIT_START,
        ST_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic wr_in;
        logic wr_cur;
        logic step;
        logic rd_en;
        logic cur_ld;
    } t_dp_cmd;

endpackage

@@ rtl/esort_if.sv @@
// ----------------------------------------------------------------------------
// esort_in_if / esort_out_if
// Valid/ready channels carrying input elements and sorted results.
// ----------------------------------------------------------------------------
interface esort_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [esort_pkg::DATA_W-1:0] value;
    logic                                last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface esort_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [esort_pkg::DATA_W-1:0] sorted_value;
    logic                                final_res;

    modport source (output valid, output sorted_value, output final_res, input ready);
    modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

@@ rtl/exchange_sort_engine_top.sv @@
// ----------------------------------------------------------------------------
// exchange_sort_engine_top
// Collects a set of signed elements, sorts ascending, streams them back.
//
// Input channel i_in: one element per transaction; last closes the set.
// Elements beyond MAX_COUNT are dropped, but their last still closes the set.
// Output channel o_out: n transactions, smallest first, final_res on the last.
// Input is taken one element per cycle while loading; it is held off while
// sorting and emitting. Sorting n elements makes n*(n-1)/2 compare steps
// through the one read port and one write port of the element store.
// Emission follows through a start state that issues the first read and
// then runs one transaction per cycle, held by the registered read data
// while the receiver stalls. Synchronous reset returns the block to
// loading with an empty set; the store itself is not cleared.
// ----------------------------------------------------------------------------
module exchange_sort_engine_top #(
    parameter int MAX_COUNT = esort_pkg::MAX_COUNT_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    esort_in_if.sink    i_in,
    esort_out_if.source o_out
);

    localparam int IW = $clog2(MAX_COUNT);

    esort_pkg::t_dp_cmd                  w_cmd;
    logic [IW-1:0]                       w_wr_addr;
    logic [IW-1:0]                       w_rd_addr;
    logic signed [esort_pkg::DATA_W-1:0] w_rd_data;
    logic                                w_in_ready;
    logic                                w_out_valid;
    logic                                w_out_final;

    esort_ctrl #(
        .MAX_COUNT (MAX_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last),
        .i_out_ready (o_out.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_out_final (w_out_final),
        .o_cmd       (w_cmd),
        .o_wr_addr   (w_wr_addr),
        .o_rd_addr   (w_rd_addr)
    );

    esort_dp #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_wr_addr  (w_wr_addr),
        .i_rd_addr  (w_rd_addr),
        .i_in_value (i_in.value),
        .o_rd_data  (w_rd_data)
    );

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = w_out_valid;
    assign o_out.sorted_value = w_rd_data;
    assign o_out.final_res    = w_out_final;

endmodule

@@ rtl/esort_dp.sv @@
// ----------------------------------------------------------------------------
// esort_dp
// Element store, running minimum register and signed compare.
// ----------------------------------------------------------------------------
module esort_dp #(
    parameter int MAX_COUNT = esort_pkg::MAX_COUNT_DEF,
    localparam int IW = $clog2(MAX_COUNT)
) (
    input  logic                                i_clk,
    input  esort_pkg::t_dp_cmd                  i_cmd,
    input  logic [IW-1:0]                       i_wr_addr,
    input  logic [IW-1:0]                       i_rd_addr,
    input  logic signed [esort_pkg::DATA_W-1:0] i_in_value,
    output logic signed [esort_pkg::DATA_W-1:0] o_rd_data
);

    logic signed [esort_pkg::DATA_W-1:0] r_mem [MAX_COUNT];
    logic signed [esort_pkg::DATA_W-1:0] r_rd_data;
    logic signed [esort_pkg::DATA_W-1:0] r_cur;
    logic signed [esort_pkg::DATA_W-1:0] w_wr_data;
    logic                                w_wr_en;
    logic                                w_greater;
    logic                                w_swap;

    assign w_greater = r_cur > r_rd_data;
    assign w_swap    = i_cmd.step && w_greater;
    assign w_wr_en   = i_cmd.wr_in || i_cmd.wr_cur || w_swap;
    assign w_wr_data = i_cmd.wr_in ? i_in_value : r_cur;
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[i_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cur_ld || w_swap) begin
            r_cur <= r_rd_data;
        end
    end

endmodule

@@ rtl/esort_ctrl.sv @@
// ----------------------------------------------------------------------------
// esort_ctrl
// Sequencer for load, exchange sort and emit phases.
// ----------------------------------------------------------------------------
module esort_ctrl #(
    parameter int MAX_COUNT = esort_pkg::MAX_COUNT_DEF,
    localparam int IW = $clog2(MAX_COUNT),
    localparam int CW = $clog2(MAX_COUNT + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output logic               o_out_final,
    output esort_pkg::t_dp_cmd o_cmd,
    output logic [IW-1:0]      o_wr_addr,
    output logic [IW-1:0]      o_rd_addr
);

    esort_pkg::t_state r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_i, n_i;
    logic [IW-1:0]     r_j, n_j;
    logic [IW-1:0]     r_k, n_k;
    logic [CW-1:0]     w_count_inc;
    logic              w_j_more;
    logic              w_i_more;
    logic              w_k_last;
    logic              w_not_full;

    assign w_not_full  = r_count < CW'(MAX_COUNT);
    assign w_count_inc = w_not_full ? r_count + CW'(1) : r_count;
    assign w_j_more    = (CW'(r_j) + CW'(1)) < r_count;
    assign w_i_more    = (CW'(r_i) + CW'(2)) < r_count;
    assign w_k_last    = (CW'(r_k) + CW'(1)) == r_count;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            esort_pkg::ST_LOAD: begin
                if (i_in_valid) begin
                    n_count = w_count_inc;
                    if (i_in_last) begin
                        n_state = (w_count_inc >= CW'(2)) ? esort_pkg::ST_SORT_START
                                                          : esort_pkg::ST_EMIT_START;
                    end
                end
            end
            esort_pkg::ST_SORT_START: begin
                n_i     = '0;
                n_state = esort_pkg::ST_OUTER_WAIT;
            end
            esort_pkg::ST_OUTER_WAIT: begin
                n_j     = r_i + IW'(1);
                n_state = esort_pkg::ST_INNER;
            end
            esort_pkg::ST_INNER: begin
                if (w_j_more) begin
                    n_j = r_j + IW'(1);
                end else begin
                    n_state = esort_pkg::ST_OUTER_END;
                end
            end
            esort_pkg::ST_OUTER_END: begin
                if (w_i_more) begin
                    n_i     = r_i + IW'(1);
                    n_state = esort_pkg::ST_OUTER_WAIT;
                end else begin
                    n_state = esort_pkg::ST_EMIT_START;
                end
            end
            esort_pkg::ST_EMIT_START: begin
                n_k     = '0;
                n_state = esort_pkg::ST_EMIT_OUT;
            end
            esort_pkg::ST_EMIT_OUT: begin
                if (i_out_ready) begin
                    if (w_k_last) begin
                        n_count = '0;
                        n_state = esort_pkg::ST_LOAD;
                    end else begin
                        n_k = r_k + IW'(1);
                    end
                end
            end
            default: n_state = esort_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_final = 1'b0;
        o_cmd       = '0;
        o_wr_addr   = '0;
        o_rd_addr   = '0;
        unique case (r_state)
            esort_pkg::ST_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.wr_in  = i_in_valid && w_not_full;
                o_wr_addr    = r_count[IW-1:0];
            end
            esort_pkg::ST_SORT_START: begin
                o_cmd.rd_en = 1'b1;
            end
            esort_pkg::ST_OUTER_WAIT: begin
                o_cmd.cur_ld = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_rd_addr    = r_i + IW'(1);
            end
            esort_pkg::ST_INNER: begin
                o_cmd.step  = 1'b1;
                o_wr_addr   = r_j;
                o_cmd.rd_en = w_j_more;
                o_rd_addr   = r_j + IW'(1);
            end
            esort_pkg::ST_OUTER_END: begin
                o_cmd.wr_cur = 1'b1;
                o_wr_addr    = r_i;
                o_cmd.rd_en  = w_i_more;
                o_rd_addr    = r_i + IW'(1);
            end
            esort_pkg::ST_EMIT_START: begin
                o_cmd.rd_en = 1'b1;
            end
            esort_pkg::ST_EMIT_OUT: begin
                o_out_valid = 1'b1;
                o_out_final = w_k_last;
                o_cmd.rd_en = i_out_ready && !w_k_last;
                o_rd_addr   = r_k + IW'(1);
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esort_pkg::ST_LOAD;
            r_count <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the exchange sort engine. A directed table covers
// single-element sets at the extremes, a short descending pair, and a full
// store closed by a dropped element. Random sets of mixed sizes follow,
// including full and overflowing sets. Each transaction is checked against
// an in-bench predictor or, for single-element rows, the table. Both
// channels idle in random bursts; one long receiver hold-off stalls input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W      = esort_pkg::DATA_W;
    localparam int MAX_COUNT   = esort_pkg::MAX_COUNT_DEF;
    localparam int NUM_DIR     = 22;
    localparam int RAND_ITEMS  = 208;
    localparam int CALM_AFTER  = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 200;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     typed;
        logic signed [DATA_W-1:0] exp_value;
    } t_row;

    typedef struct {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
    } t_sorted;

    logic i_clk;
    logic i_rst_n;

    esort_in_if  in_ch ();
    esort_out_if out_ch ();

    exchange_sort_engine_top #(
        .MAX_COUNT(MAX_COUNT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    logic signed [DATA_W-1:0] set_buf[$];
    t_sorted                  sorted_pending[$];
    t_row                     dir_rows[NUM_DIR];

    int  errors          = 0;
    int  items_sent      = 0;
    int  sets_closed     = 0;
    int  results_checked = 0;
    bit  calm            = 1'b0;
    bit  hold_req        = 1'b0;
    bit  hold_done       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Store up to MAX_COUNT; on last, sort by exchange and queue results if predict.
    function automatic void absorb_element(logic signed [DATA_W-1:0] v, logic l, bit predict);
        logic signed [DATA_W-1:0] tmp;
        t_sorted                  res;
        if (set_buf.size() < MAX_COUNT) begin
            set_buf.push_back(v);
        end
        if (l) begin
            for (int i = 0; i + 1 < set_buf.size(); i++) begin
                for (int j = i + 1; j < set_buf.size(); j++) begin
                    if (set_buf[i] > set_buf[j]) begin
                        tmp        = set_buf[i];
                        set_buf[i] = set_buf[j];
                        set_buf[j] = tmp;
                    end
                end
            end
            if (predict) begin
                for (int k = 0; k < set_buf.size(); k++) begin
                    res.sorted_value = set_buf[k];
                    res.final_res    = (k + 1 == set_buf.size());
                    sorted_pending.push_back(res);
                end
            end
            set_buf.delete();
            sets_closed++;
        end
    endfunction

    task automatic offer(logic signed [DATA_W-1:0] v, logic l);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= l;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (items_sent >= CALM_AFTER) calm = 1'b1;
    endtask

    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_sorted want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (sorted_pending.size() == 0) begin
                $error("unexpected transaction: sorted_value=%0d final_res=%0d",
                       out_ch.sorted_value, out_ch.final_res);
                errors++;
            end else begin
                want = sorted_pending.pop_front();
                if (out_ch.sorted_value !== want.sorted_value) begin
                    $error("sorted_value mismatch: expected %0d, actual %0d",
                           want.sorted_value, out_ch.sorted_value);
                    errors++;
                end
                if (out_ch.final_res !== want.final_res) begin
                    $error("final_res mismatch: expected %0d, actual %0d",
                           want.final_res, out_ch.final_res);
                    errors++;
                end
                results_checked++;
            end
        end
    end

    initial begin
        int                       set_len;
        int                       kind;
        logic signed [DATA_W-1:0] v;
        logic                     l;
        t_sorted                  res;
        bit                       first_set;

        dir_rows = '{
            '{VAL_MAX,      1'b1, 1'b1, VAL_MAX},
            '{VAL_MIN,      1'b1, 1'b1, VAL_MIN},
            '{32'sd0,       1'b1, 1'b1, 32'sd0},
            '{32'sd9,       1'b0, 1'b0, 32'sd0},
            '{-32'sd9,      1'b1, 1'b0, 32'sd0},
            '{VAL_MAX,      1'b0, 1'b0, 32'sd0},
            '{VAL_MIN,      1'b0, 1'b0, 32'sd0},
            '{32'sd0,       1'b0, 1'b0, 32'sd0},
            '{-32'sd1,      1'b0, 1'b0, 32'sd0},
            '{32'sd1,       1'b0, 1'b0, 32'sd0},
            '{-32'sd1,      1'b0, 1'b0, 32'sd0},
            '{VAL_MAX,      1'b0, 1'b0, 32'sd0},
            '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
            '{32'shAAAA_AAAA, 1'b0, 1'b0, 32'sd0},
            '{32'sd100,     1'b0, 1'b0, 32'sd0},
            '{-32'sd100,    1'b0, 1'b0, 32'sd0},
            '{32'sd0,       1'b0, 1'b0, 32'sd0},
            '{VAL_MIN,      1'b0, 1'b0, 32'sd0},
            '{32'sd3,       1'b0, 1'b0, 32'sd0},
            '{32'sd2,       1'b0, 1'b0, 32'sd0},
            '{32'sd1,       1'b0, 1'b0, 32'sd0},
            '{32'sh1234_5678, 1'b1, 1'b0, 32'sd0}
        };

        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last  <= 1'b0;
        i_rst_n     <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n     <= 1'b1;

        for (int r = 0; r < NUM_DIR; r++) begin
            offer(dir_rows[r].value, dir_rows[r].last);
            absorb_element(dir_rows[r].value, dir_rows[r].last, !dir_rows[r].typed);
            if (dir_rows[r].typed) begin
                res.sorted_value = dir_rows[r].exp_value;
                res.final_res    = 1'b1;
                sorted_pending.push_back(res);
            end
        end

        // Stall the receiver while a full set is offered behind it.
        hold_req  = 1'b1;
        first_set = 1'b1;
        while (items_sent < NUM_DIR + RAND_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (first_set || kind == 0) begin
                set_len = MAX_COUNT;
            end else if (kind == 1) begin
                set_len = $urandom_range(MAX_COUNT + 1, MAX_COUNT + 4);
            end else begin
                set_len = $urandom_range(1, 6);
            end
            first_set = 1'b0;
            for (int k = 0; k < set_len; k++) begin
                case ($urandom_range(0, 7))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MAX;
                    2, 3:    v = $signed($urandom_range(0, 8)) - 4;
                    default: v = $urandom;
                endcase
                l = (k == set_len - 1);
                offer(v, l);
                absorb_element(v, l, 1'b1);
            end
        end
        in_ch.valid <= 1'b0;

        while (sorted_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d elements in %0d sets, checked %0d sorted transactions",
                 items_sent, sets_closed, results_checked);
        $display("including full and overflowing stores and a long receiver hold-off.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/esort_pkg.sv
rtl/esort_if.sv
rtl/esort_dp.sv
rtl/esort_ctrl.sv
rtl/exchange_sort_engine_top.sv
tb/tb_top.sv
